FILE: hw/rtl/gpr_pkg.sv
// ============================================================================
// gpr_pkg: shared types and constants for the partition refinement pass
// Sizes of the graph stores, the command codes, the sequencer states and
// the request and response bundles of the shared arithmetic unit.
// ============================================================================
package gpr_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_ENTRIES  = 8192;
    localparam int MAX_PARTS    = 16;
    localparam int WEIGHT_BITS  = 16;

    localparam int VIDX_W = $clog2(MAX_VERTICES);      // vertex index
    localparam int EIDX_W = $clog2(MAX_ENTRIES);       // entry index
    localparam int PART_W = $clog2(MAX_PARTS);         // part number
    localparam int POS_W  = 14;                        // position field
    localparam int CNT_W  = VIDX_W + 1;                // vertex count
    localparam int WSUM_W = 29;                        // per-vertex weight sum
    localparam int GAIN_W = 40;                        // pair gain total
    localparam int CUT_W  = 29;                        // cut accumulator

    // Neighbour entries keep the low vertex bits plus an out-of-range flag.
    localparam int NBR_W  = VIDX_W + 1;
    // Target entries keep a part number plus a "no target" flag on top.
    localparam int TGT_W  = PART_W + 1;

    typedef enum logic [2:0] {
        KIND_SET_PART   = 3'd0,
        KIND_SET_OFFSET = 3'd1,
        KIND_SET_ENTRY  = 3'd2,
        KIND_RUN        = 3'd3,
        KIND_QUERY      = 3'd4
    } kind_t;

    typedef enum logic {
        CFG_NUM_VERTICES = 1'b0,
        CFG_NUM_PARTS    = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_GT
    } alu_op_t;

    typedef struct packed {
        alu_op_t             op;
        logic [GAIN_W-1:0]   a;
        logic [GAIN_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   value;
        logic                gt;
    } alu_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_Q_OUT,
        S_R_START,
        S_R_LO,
        S_R_VTX,
        S_R_VTX2,
        S_R_ENT,
        S_R_NB,
        S_R_ACC,
        S_R_VEND,
        S_R_CUT,
        S_G_RD,
        S_G_CHK,
        S_G_ADD,
        S_M_RD,
        S_M_CHK,
        S_M_G1,
        S_M_G2,
        S_R_OUT
    } state_t;

    // Offsets beyond the entry store are treated as its end.
    function automatic logic [POS_W-1:0] clamp_offset(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        r = (v > POS_W'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES) : v;
        return r;
    endfunction

endpackage

FILE: hw/rtl/gpr_ram.sv
// ============================================================================
// gpr_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ============================================================================
module gpr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/gpr_alu.sv
// ============================================================================
// gpr_alu: shared arithmetic unit of the refinement sequencer
// A combinational unit that serves add, subtract and greater-than requests.
// ============================================================================
module gpr_alu (
    input  gpr_pkg::alu_req_t req,
    output gpr_pkg::alu_rsp_t rsp
);

    logic [gpr_pkg::GAIN_W:0] diff;

    // Greater-than comes from the borrow of b - a.
    assign diff = {1'b0, req.b} - {1'b0, req.a};

    always_comb
    begin
        rsp.gt = diff[gpr_pkg::GAIN_W];
        unique case (req.op)
            gpr_pkg::ALU_ADD: rsp.value = req.a + req.b;
            gpr_pkg::ALU_SUB: rsp.value = req.a - req.b;
            gpr_pkg::ALU_GT:  rsp.value = '0;
            default:          rsp.value = '0;
        endcase
    end

endmodule

FILE: hw/rtl/graph_partition_refine_pass.sv
// ============================================================================
// graph_partition_refine_pass: boundary refinement over a CSR graph
// Timing: a load is written to its store when the beat is taken; a query
// registers its report in S_Q_OUT once the result channel is free. A run
// walks the vertices in use and their adjacency entries, paced by the single
// read port of each store and the shared arithmetic unit. One item at a time.
// Reset: control registers reset at once, no clearing pass; graph stores hold garbage.
// ============================================================================
//
// Three passes are sequenced over the stores. Pass one walks every vertex's
// entries and sums internal and external weight through the shared adder,
// then records target and boundary. Pass two accumulates move gains per
// ordered part pair; the pair store carries valid bits cleared when a run
// starts. Pass three moves a vertex whose direction beats its reverse.
// Per-vertex result stores are not cleared: a query at or above the latest
// run's vertex count reads its weights and boundary flag as zero instead.
module graph_partition_refine_pass (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [10:0]                 cfg_data,
    // command channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  kind,
    input  logic [13:0]                 position,
    input  logic [13:0]                 item_value,
    input  logic [15:0]                 edge_weight,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        result_kind,
    output logic [27:0]                 edge_cut,
    output logic [10:0]                 boundary_count,
    output logic [10:0]                 improving_count,
    output logic [3:0]                  vertex_part,
    output logic [28:0]                 internal_weight,
    output logic [28:0]                 external_weight,
    output logic                        on_boundary
);

    localparam int VW = gpr_pkg::VIDX_W;
    localparam int EW = gpr_pkg::EIDX_W;
    localparam int PW = gpr_pkg::PART_W;
    localparam int CW = gpr_pkg::CNT_W;
    localparam int SW = gpr_pkg::WSUM_W;
    localparam int GW = gpr_pkg::GAIN_W;
    localparam int OW = gpr_pkg::POS_W;
    localparam int GA = 2 * PW;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    gpr_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    num_vertices_reg, num_vertices_next;
    logic [4:0]       num_parts_reg, num_parts_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [OW-1:0]    j_reg, j_next;
    logic [OW-1:0]    lo_reg, lo_next;
    logic [OW-1:0]    hi_reg, hi_next;
    logic [PW-1:0]    mine_reg, mine_next;
    logic [SW-1:0]    tin_reg, tin_next;
    logic [SW-1:0]    tex_reg, tex_next;
    logic [PW-1:0]    last_reg, last_next;
    logic             bnd_reg, bnd_next;
    logic [gpr_pkg::CUT_W-1:0] cut_reg, cut_next;
    logic [CW-1:0]    nbnd_reg, nbnd_next;
    logic [CW-1:0]    nimp_reg, nimp_next;
    logic [PW-1:0]    a_reg, a_next;
    logic [PW-1:0]    b_reg, b_next;
    logic [SW-1:0]    diff_reg, diff_next;
    logic [GW-1:0]    g1_reg, g1_next;
    logic [GA-1:0]    gaddr_reg, gaddr_next;
    logic [CW-1:0]    run_nv_reg, run_nv_next;
    logic             q_ok_reg, q_ok_next;
    logic             q_run_reg, q_run_next;
    logic [(1<<GA)-1:0] gvalid_reg, gvalid_next;

    logic             out_valid_reg, out_valid_next;
    logic             rkind_reg, rkind_next;
    logic [27:0]      ecut_reg, ecut_next;
    logic [10:0]      bcnt_reg, bcnt_next;
    logic [10:0]      icnt_reg, icnt_next;
    logic [3:0]       vpart_out_reg, vpart_out_next;
    logic [28:0]      iw_reg, iw_next;
    logic [28:0]      ew_reg, ew_next;
    logic             onb_reg, onb_next;

    // ------------------------------------------------------------------
    // Store ports
    // ------------------------------------------------------------------
    logic          vp_we, vp_re;
    logic [VW-1:0] vp_waddr, vp_raddr;
    logic [PW-1:0] vp_wdata, vp_rdata;

    logic          of_we, of_re;
    logic [CW-1:0] of_waddr, of_raddr;
    logic [OW-1:0] of_wdata, of_rdata;

    logic          en_we, en_re;
    logic [EW-1:0] en_waddr, en_raddr;
    logic [gpr_pkg::NBR_W-1:0] nb_wdata, nb_rdata;
    logic [gpr_pkg::WEIGHT_BITS-1:0] wt_wdata, wt_rdata;

    logic          vs_we, vs_re;
    logic [VW-1:0] vs_waddr, vs_raddr;
    logic [SW-1:0] in_wdata, in_rdata, ex_wdata, ex_rdata;
    logic [gpr_pkg::TGT_W-1:0] tg_wdata, tg_rdata;
    logic          bd_wdata, bd_rdata;

    logic          gn_we, gn_re;
    logic [GA-1:0] gn_waddr, gn_raddr;
    logic [GW-1:0] gn_wdata, gn_rdata;

    gpr_pkg::alu_req_t alu_req;
    gpr_pkg::alu_rsp_t alu_rsp;

    logic [CW-1:0] nv;
    logic [4:0]    np;
    logic [GW-1:0] gain_val;
    logic          out_free;
    logic          elig;
    logic [PW-1:0] nb_part;

    assign nv = (num_vertices_reg > CW'(gpr_pkg::MAX_VERTICES)) ?
                CW'(gpr_pkg::MAX_VERTICES) : num_vertices_reg;
    assign np = (num_parts_reg > 5'(gpr_pkg::MAX_PARTS)) ?
                5'(gpr_pkg::MAX_PARTS) : num_parts_reg;

    // A pair entry not touched in this run reads as zero.
    assign gain_val = gvalid_reg[gaddr_reg] ? gn_rdata : '0;
    assign out_free = !out_valid_reg || out_ready;

    // Move is proposed by a boundary vertex with a target, both parts in use.
    assign elig = bd_rdata && !tg_rdata[PW] &&
                  ({1'b0, vp_rdata} < np) && ({1'b0, tg_rdata[PW-1:0]} < np);
    assign nb_part = vp_rdata;

    gpr_ram #(.DEPTH(gpr_pkg::MAX_VERTICES), .WIDTH(PW)) u_vpart (
        .clk(clk), .we(vp_we), .waddr(vp_waddr), .wdata(vp_wdata),
        .re(vp_re), .raddr(vp_raddr), .rdata(vp_rdata)
    );

    gpr_ram #(.DEPTH(gpr_pkg::MAX_VERTICES + 1), .WIDTH(OW)) u_offset (
        .clk(clk), .we(of_we), .waddr(of_waddr), .wdata(of_wdata),
        .re(of_re), .raddr(of_raddr), .rdata(of_rdata)
    );

    gpr_ram #(.DEPTH(gpr_pkg::MAX_ENTRIES), .WIDTH(gpr_pkg::NBR_W)) u_nbr (
        .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(nb_wdata),
        .re(en_re), .raddr(en_raddr), .rdata(nb_rdata)
    );

    gpr_ram #(.DEPTH(gpr_pkg::MAX_ENTRIES), .WIDTH(gpr_pkg::WEIGHT_BITS)) u_wt (
        .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(wt_wdata),
        .re(en_re), .raddr(en_raddr), .rdata(wt_rdata)
    );

    gpr_ram #(.DEPTH(gpr_pkg::MAX_VERTICES), .WIDTH(SW)) u_int (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(in_wdata),
        .re(vs_re), .raddr(vs_raddr), .rdata(in_rdata)
    );

    gpr_ram #(.DEPTH(gpr_pkg::MAX_VERTICES), .WIDTH(SW)) u_ext (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(ex_wdata),
        .re(vs_re), .raddr(vs_raddr), .rdata(ex_rdata)
    );

    gpr_ram #(.DEPTH(gpr_pkg::MAX_VERTICES), .WIDTH(gpr_pkg::TGT_W)) u_tgt (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(tg_wdata),
        .re(vs_re), .raddr(vs_raddr), .rdata(tg_rdata)
    );

    gpr_ram #(.DEPTH(gpr_pkg::MAX_VERTICES), .WIDTH(1)) u_bnd (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(bd_wdata),
        .re(vs_re), .raddr(vs_raddr), .rdata(bd_rdata)
    );

    gpr_ram #(.DEPTH(1 << GA), .WIDTH(GW)) u_gain (
        .clk(clk), .we(gn_we), .waddr(gn_waddr), .wdata(gn_wdata),
        .re(gn_re), .raddr(gn_raddr), .rdata(gn_rdata)
    );

    gpr_alu u_alu (
        .req(alu_req),
        .rsp(alu_rsp)
    );

    // ------------------------------------------------------------------
    // Control and status registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gpr_pkg::S_IDLE;
            num_vertices_reg <= CW'(gpr_pkg::MAX_VERTICES);
            num_parts_reg    <= 5'd2;
            run_nv_reg       <= '0;
            gvalid_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            num_vertices_reg <= num_vertices_next;
            num_parts_reg    <= num_parts_next;
            run_nv_reg       <= run_nv_next;
            gvalid_reg       <= gvalid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mine_reg      <= mine_next;
        tin_reg       <= tin_next;
        tex_reg       <= tex_next;
        last_reg      <= last_next;
        bnd_reg       <= bnd_next;
        cut_reg       <= cut_next;
        nbnd_reg      <= nbnd_next;
        nimp_reg      <= nimp_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        diff_reg      <= diff_next;
        g1_reg        <= g1_next;
        gaddr_reg     <= gaddr_next;
        q_ok_reg      <= q_ok_next;
        q_run_reg     <= q_run_next;
        rkind_reg     <= rkind_next;
        ecut_reg      <= ecut_next;
        bcnt_reg      <= bcnt_next;
        icnt_reg      <= icnt_next;
        vpart_out_reg <= vpart_out_next;
        iw_reg        <= iw_next;
        ew_reg        <= ew_next;
        onb_reg       <= onb_next;
    end

    assign in_ready        = (state_reg == gpr_pkg::S_IDLE);
    assign out_valid       = out_valid_reg;
    assign result_kind     = rkind_reg;
    assign edge_cut        = ecut_reg;
    assign boundary_count  = bcnt_reg;
    assign improving_count = icnt_reg;
    assign vertex_part     = vpart_out_reg;
    assign internal_weight = iw_reg;
    assign external_weight = ew_reg;
    assign on_boundary     = onb_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        num_vertices_next = num_vertices_reg;
        num_parts_next    = num_parts_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mine_next         = mine_reg;
        tin_next          = tin_reg;
        tex_next          = tex_reg;
        last_next         = last_reg;
        bnd_next          = bnd_reg;
        cut_next          = cut_reg;
        nbnd_next         = nbnd_reg;
        nimp_next         = nimp_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        diff_next         = diff_reg;
        g1_next           = g1_reg;
        gaddr_next        = gaddr_reg;
        run_nv_next       = run_nv_reg;
        q_ok_next         = q_ok_reg;
        q_run_next        = q_run_reg;
        gvalid_next       = gvalid_reg;
        out_valid_next    = out_valid_reg;
        rkind_next        = rkind_reg;
        ecut_next         = ecut_reg;
        bcnt_next         = bcnt_reg;
        icnt_next         = icnt_reg;
        vpart_out_next    = vpart_out_reg;
        iw_next           = iw_reg;
        ew_next           = ew_reg;
        onb_next          = onb_reg;

        vp_we = 1'b0; vp_re = 1'b0; vp_waddr = '0; vp_raddr = '0; vp_wdata = '0;
        of_we = 1'b0; of_re = 1'b0; of_waddr = '0; of_raddr = '0; of_wdata = '0;
        en_we = 1'b0; en_re = 1'b0; en_waddr = '0; en_raddr = '0;
        nb_wdata = '0; wt_wdata = '0;
        vs_we = 1'b0; vs_re = 1'b0; vs_waddr = '0; vs_raddr = '0;
        in_wdata = '0; ex_wdata = '0; tg_wdata = '0; bd_wdata = 1'b0;
        gn_we = 1'b0; gn_re = 1'b0; gn_waddr = '0; gn_raddr = '0; gn_wdata = '0;

        alu_req.op = gpr_pkg::ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (gpr_pkg::cfg_idx_t'(cfg_index))
                gpr_pkg::CFG_NUM_VERTICES: num_vertices_next = cfg_data[CW-1:0];
                gpr_pkg::CFG_NUM_PARTS:    num_parts_next    = cfg_data[4:0];
                default:                   num_parts_next    = num_parts_reg;
            endcase
        end

        unique case (state_reg)
            gpr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (gpr_pkg::kind_t'(kind))
                        gpr_pkg::KIND_SET_PART:
                        begin
                            vp_we    = (position < OW'(gpr_pkg::MAX_VERTICES));
                            vp_waddr = position[VW-1:0];
                            vp_wdata = item_value[PW-1:0];
                        end
                        gpr_pkg::KIND_SET_OFFSET:
                        begin
                            of_we    = (position <= OW'(gpr_pkg::MAX_VERTICES));
                            of_waddr = position[CW-1:0];
                            of_wdata = item_value;
                        end
                        gpr_pkg::KIND_SET_ENTRY:
                        begin
                            en_we    = (position < OW'(gpr_pkg::MAX_ENTRIES));
                            en_waddr = position[EW-1:0];
                            nb_wdata = {(item_value >= OW'(gpr_pkg::MAX_VERTICES)),
                                        item_value[VW-1:0]};
                            wt_wdata = edge_weight[gpr_pkg::WEIGHT_BITS-1:0];
                        end
                        gpr_pkg::KIND_RUN:
                        begin
                            state_next = gpr_pkg::S_R_START;
                        end
                        gpr_pkg::KIND_QUERY:
                        begin
                            vp_re      = 1'b1;
                            vp_raddr   = position[VW-1:0];
                            vs_re      = 1'b1;
                            vs_raddr   = position[VW-1:0];
                            q_ok_next  = (position < OW'(gpr_pkg::MAX_VERTICES));
                            q_run_next = (position < OW'(run_nv_reg));
                            state_next = gpr_pkg::S_Q_OUT;
                        end
                        default:
                        begin
                            state_next = gpr_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            gpr_pkg::S_Q_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rkind_next     = 1'b1;
                    ecut_next      = '0;
                    bcnt_next      = '0;
                    icnt_next      = '0;
                    vpart_out_next = q_ok_reg ? vp_rdata : '0;
                    iw_next        = q_run_reg ? in_rdata : '0;
                    ew_next        = q_run_reg ? ex_rdata : '0;
                    onb_next       = q_run_reg && bd_rdata;
                    state_next     = gpr_pkg::S_IDLE;
                end
            end

            // ---------------- pass one: weights, target, boundary
            gpr_pkg::S_R_START:
            begin
                of_re       = 1'b1;
                of_raddr    = '0;
                i_next      = '0;
                cut_next    = '0;
                nbnd_next   = '0;
                nimp_next   = '0;
                gvalid_next = '0;
                run_nv_next = nv;
                state_next  = gpr_pkg::S_R_LO;
            end

            gpr_pkg::S_R_LO:
            begin
                lo_next    = gpr_pkg::clamp_offset(of_rdata);
                state_next = (nv == '0) ? gpr_pkg::S_R_OUT : gpr_pkg::S_R_VTX;
            end

            gpr_pkg::S_R_VTX:
            begin
                of_re      = 1'b1;
                of_raddr   = i_reg + CW'(1);
                vp_re      = 1'b1;
                vp_raddr   = i_reg[VW-1:0];
                state_next = gpr_pkg::S_R_VTX2;
            end

            gpr_pkg::S_R_VTX2:
            begin
                hi_next    = gpr_pkg::clamp_offset(of_rdata);
                mine_next  = vp_rdata;
                j_next     = lo_reg;
                tin_next   = '0;
                tex_next   = '0;
                last_next  = '0;
                state_next = gpr_pkg::S_R_ENT;
            end

            gpr_pkg::S_R_ENT:
            begin
                if (j_reg < hi_reg)
                begin
                    en_re      = 1'b1;
                    en_raddr   = j_reg[EW-1:0];
                    state_next = gpr_pkg::S_R_NB;
                end
                else
                begin
                    state_next = gpr_pkg::S_R_VEND;
                end
            end

            gpr_pkg::S_R_NB:
            begin
                if (nb_rdata[VW])
                begin
                    // Neighbour outside the vertex store: entry is skipped.
                    j_next     = j_reg + OW'(1);
                    state_next = gpr_pkg::S_R_ENT;
                end
                else
                begin
                    vp_re      = 1'b1;
                    vp_raddr   = nb_rdata[VW-1:0];
                    state_next = gpr_pkg::S_R_ACC;
                end
            end

            gpr_pkg::S_R_ACC:
            begin
                alu_req.op = gpr_pkg::ALU_ADD;
                alu_req.a  = GW'(wt_rdata);
                if (nb_part == mine_reg)
                begin
                    alu_req.b = GW'(tin_reg);
                    tin_next  = alu_rsp.value[SW-1:0];
                end
                else
                begin
                    alu_req.b = GW'(tex_reg);
                    tex_next  = alu_rsp.value[SW-1:0];
                    last_next = nb_part;
                end
                j_next     = j_reg + OW'(1);
                state_next = gpr_pkg::S_R_ENT;
            end

            gpr_pkg::S_R_VEND:
            begin
                alu_req.op = gpr_pkg::ALU_GT;
                alu_req.a  = GW'(tex_reg);
                alu_req.b  = GW'(tin_reg);
                bnd_next   = (tex_reg != '0) || (hi_reg <= lo_reg);
                vs_we      = 1'b1;
                vs_waddr   = i_reg[VW-1:0];
                in_wdata   = tin_reg;
                ex_wdata   = tex_reg;
                bd_wdata   = (tex_reg != '0) || (hi_reg <= lo_reg);
                tg_wdata   = alu_rsp.gt ? {1'b0, last_reg} : {1'b1, {PW{1'b0}}};
                if (alu_rsp.gt)
                begin
                    nimp_next = nimp_reg + CW'(1);
                end
                state_next = gpr_pkg::S_R_CUT;
            end

            gpr_pkg::S_R_CUT:
            begin
                alu_req.op = gpr_pkg::ALU_ADD;
                alu_req.a  = GW'(cut_reg);
                alu_req.b  = GW'(tex_reg);
                if (bnd_reg)
                begin
                    cut_next  = alu_rsp.value[gpr_pkg::CUT_W-1:0];
                    nbnd_next = nbnd_reg + CW'(1);
                end
                lo_next = hi_reg;
                if (i_reg + CW'(1) < nv)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = gpr_pkg::S_R_VTX;
                end
                else
                begin
                    i_next     = '0;
                    state_next = gpr_pkg::S_G_RD;
                end
            end

            // ---------------- pass two: gain totals per part pair
            gpr_pkg::S_G_RD:
            begin
                vp_re      = 1'b1;
                vp_raddr   = i_reg[VW-1:0];
                vs_re      = 1'b1;
                vs_raddr   = i_reg[VW-1:0];
                state_next = gpr_pkg::S_G_CHK;
            end

            gpr_pkg::S_G_CHK:
            begin
                alu_req.op = gpr_pkg::ALU_SUB;
                alu_req.a  = GW'(ex_rdata);
                alu_req.b  = GW'(in_rdata);
                diff_next  = alu_rsp.value[SW-1:0];
                if (elig)
                begin
                    gn_re      = 1'b1;
                    gn_raddr   = {vp_rdata, tg_rdata[PW-1:0]};
                    gaddr_next = {vp_rdata, tg_rdata[PW-1:0]};
                    state_next = gpr_pkg::S_G_ADD;
                end
                else if (i_reg + CW'(1) < nv)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = gpr_pkg::S_G_RD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = gpr_pkg::S_M_RD;
                end
            end

            gpr_pkg::S_G_ADD:
            begin
                alu_req.op  = gpr_pkg::ALU_ADD;
                alu_req.a   = gain_val;
                alu_req.b   = GW'(diff_reg);
                gn_we       = 1'b1;
                gn_waddr    = gaddr_reg;
                gn_wdata    = alu_rsp.value;
                gvalid_next[gaddr_reg] = 1'b1;
                if (i_reg + CW'(1) < nv)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = gpr_pkg::S_G_RD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = gpr_pkg::S_M_RD;
                end
            end

            // ---------------- pass three: apply moves that win their pair
            gpr_pkg::S_M_RD:
            begin
                vp_re      = 1'b1;
                vp_raddr   = i_reg[VW-1:0];
                vs_re      = 1'b1;
                vs_raddr   = i_reg[VW-1:0];
                state_next = gpr_pkg::S_M_CHK;
            end

            gpr_pkg::S_M_CHK:
            begin
                if (elig)
                begin
                    a_next     = vp_rdata;
                    b_next     = tg_rdata[PW-1:0];
                    gn_re      = 1'b1;
                    gn_raddr   = {vp_rdata, tg_rdata[PW-1:0]};
                    gaddr_next = {vp_rdata, tg_rdata[PW-1:0]};
                    state_next = gpr_pkg::S_M_G1;
                end
                else if (i_reg + CW'(1) < nv)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = gpr_pkg::S_M_RD;
                end
                else
                begin
                    state_next = gpr_pkg::S_R_OUT;
                end
            end

            gpr_pkg::S_M_G1:
            begin
                g1_next    = gain_val;
                gn_re      = 1'b1;
                gn_raddr   = {b_reg, a_reg};
                gaddr_next = {b_reg, a_reg};
                state_next = gpr_pkg::S_M_G2;
            end

            gpr_pkg::S_M_G2:
            begin
                alu_req.op = gpr_pkg::ALU_GT;
                alu_req.a  = g1_reg;
                alu_req.b  = gain_val;
                if (alu_rsp.gt)
                begin
                    vp_we    = 1'b1;
                    vp_waddr = i_reg[VW-1:0];
                    vp_wdata = b_reg;
                end
                if (i_reg + CW'(1) < nv)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = gpr_pkg::S_M_RD;
                end
                else
                begin
                    state_next = gpr_pkg::S_R_OUT;
                end
            end

            gpr_pkg::S_R_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rkind_next     = 1'b0;
                    ecut_next      = cut_reg[28:1];
                    bcnt_next      = nbnd_reg;
                    icnt_next      = nimp_reg;
                    vpart_out_next = '0;
                    iw_next        = '0;
                    ew_next        = '0;
                    onb_next       = 1'b0;
                    state_next     = gpr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = gpr_pkg::S_IDLE;
            end
        endcase
    end

endmodule
